>>> src/move_to_back_order_list_assert.svh
// Assertion helpers for the order list block
`ifndef MOVE_TO_BACK_ORDER_LIST_ASSERT_SVH
`define MOVE_TO_BACK_ORDER_LIST_ASSERT_SVH

// same-cycle implication
`define MTBOL_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MTBOL_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/mtbol_pkg.sv
`default_nettype none
package mtbol_pkg;

  localparam int MODE_W  = 2;
  localparam int ENTRY_W = 4;
  localparam int COUNT_W = 5;
  localparam int OUT_W   = 4;

  localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DUMP = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

  typedef struct packed {
    logic capture;
    logic load;
    logic move_rank;
    logic move_update;
    logic dump_step;
  } cmd_t;

  typedef struct packed {
    logic dump_final;
  } sts_t;

endpackage
`default_nettype wire

>>> src/mtbol_ctrl.sv
`default_nettype none
module mtbol_ctrl
  import mtbol_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [MODE_W-1:0] in_mode,
  input  wire sts_t              sts,
  output logic                   in_ready,
  output cmd_t                   cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_DUMP
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.capture = accept;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_LOAD: cmd.load = 1'b1;
            MODE_MOVE: state_next = ST_MOVE_RD;
            MODE_DUMP: state_next = ST_DUMP;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_MOVE_RD: begin
        cmd.move_rank = 1'b1;
        state_next    = ST_MOVE_WR;
      end
      ST_MOVE_WR: begin
        cmd.move_update = 1'b1;
        state_next      = ST_IDLE;
      end
      ST_DUMP: begin
        cmd.dump_step = 1'b1;
        if (sts.dump_final) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

>>> src/mtbol_dp.sv
`default_nettype none
module mtbol_dp
  import mtbol_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  input  wire logic [ENTRY_W-1:0] entry_in,
  input  wire logic [COUNT_W-1:0] active_count,
  input  wire logic               out_ready,
  output sts_t                    sts,
  output logic                    out_valid,
  output logic [OUT_W-1:0]        out_value,
  output logic                    out_last
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int RW = IW;
  localparam int PW = IW + OUT_W;

  logic [RW-1:0]          rank [MAX_ENTRIES];
  logic [COUNT_W-1:0]     load_pos;
  logic [ENTRY_W-1:0]     v_reg;
  logic [RW-1:0]          r_reg;
  logic [RW-1:0]          scan_rank;
  logic [COUNT_W-1:0]     emit_cnt;
  logic [MAX_ENTRIES-1:0] emitted;

  logic [COUNT_W-1:0]     n;
  logic [MAX_ENTRIES-1:0] active;
  logic [MAX_ENTRIES-1:0] hit_in;
  logic [MAX_ENTRIES-1:0] hit_v;
  logic [MAX_ENTRIES-1:0] match;
  logic [RW-1:0]          r_sel;
  logic [IW-1:0]          pick;
  logic [PW-1:0]          pick_wide;
  logic                   hit_any;
  logic                   slot_free;
  logic                   load_ok;
  logic                   move_ok;

  // effective count, clamped to 1..MAX_ENTRIES
  always_comb begin
    n = active_count;
    if (active_count == '0) begin
      n = COUNT_W'(1);
    end else if (int'(active_count) > MAX_ENTRIES) begin
      n = COUNT_W'(MAX_ENTRIES);
    end
  end

  always_comb begin
    for (int e = 0; e < MAX_ENTRIES; e++) begin
      active[e] = (e < int'(n));
      hit_in[e] = (int'(entry_in) == e);
      hit_v[e]  = (int'(v_reg) == e);
      match[e]  = active[e] && !emitted[e] && (rank[e] == scan_rank);
    end
  end

  always_comb begin
    r_sel = '0;
    for (int e = 0; e < MAX_ENTRIES; e++) begin
      if (hit_v[e]) begin
        r_sel = rank[e];
      end
    end
  end

  // lowest entry index among those holding the scanned rank
  always_comb begin
    pick = '0;
    for (int e = MAX_ENTRIES - 1; e >= 0; e--) begin
      if (match[e]) begin
        pick = IW'(e);
      end
    end
  end

  assign pick_wide = PW'(pick);
  assign hit_any   = |match;
  assign slot_free = !out_valid || out_ready;
  assign load_ok   = (load_pos < n) && ({1'b0, entry_in} < n);
  assign move_ok   = ({1'b0, v_reg} < n);

  assign sts.dump_final = slot_free && hit_any && (emit_cnt == n - COUNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < MAX_ENTRIES; e++) begin
        rank[e] <= RW'(e);
      end
      load_pos  <= '0;
      scan_rank <= '0;
      emit_cnt  <= '0;
      emitted   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.capture) begin
        v_reg     <= entry_in;
        scan_rank <= '0;
        emit_cnt  <= '0;
        emitted   <= '0;
      end

      if (cmd.load && load_ok) begin
        for (int e = 0; e < MAX_ENTRIES; e++) begin
          if (hit_in[e]) begin
            rank[e] <= RW'(load_pos);
          end
        end
        load_pos <= load_pos + COUNT_W'(1);
      end

      if (cmd.move_rank) begin
        r_reg <= r_sel;
      end

      if (cmd.move_update && move_ok) begin
        for (int e = 0; e < MAX_ENTRIES; e++) begin
          if (active[e]) begin
            if (hit_v[e]) begin
              rank[e] <= RW'(n - COUNT_W'(1));
            end else if (rank[e] > r_reg) begin
              rank[e] <= rank[e] - RW'(1);
            end
          end
        end
      end

      if (cmd.dump_step && slot_free && hit_any) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cmd.dump_step && slot_free) begin
        if (hit_any) begin
          for (int e = 0; e < MAX_ENTRIES; e++) begin
            if (int'(pick) == e) begin
              emitted[e] <= 1'b1;
            end
          end
          emit_cnt  <= emit_cnt + COUNT_W'(1);
          out_value <= pick_wide[OUT_W-1:0];
          out_last  <= (emit_cnt == n - COUNT_W'(1));
        end else begin
          scan_rank <= scan_rank + RW'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> src/move_to_back_order_list.sv
`default_nettype none
// Move-to-back order list. Each entry holds a rank; reading entries by rising
// rank (ties to the lower index) gives the order from front to back. A load
// (tuser 0) gives an entry the next rank. A move (tuser 1) sends an entry to
// the back by an accept, a rank read, then one parallel update of all rank
// cells. A dump (tuser 2) emits the n active entries, one per cycle unless
// m_axis_tready stalls it, tlast on the final one; the rank scan also pauses
// on each rank value left unused below the highest rank while stepping. An
// output register lets the next item be accepted while the final dump item
// still waits. The count register (reset 16, its value clamped to
// 1..MAX_ENTRIES when used) is written through cfg_* and is always ready;
// write it only while the block is idle.
module move_to_back_order_list
  import mtbol_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [3:0] entry_value
  input  wire logic [1:0] s_axis_tuser,   // [1:0] mode
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [3:0] out_value
  output logic            m_axis_tlast,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [4:0] cfg_data        // [4:0] active_count
);

  logic [COUNT_W-1:0] active_count;
  logic [OUT_W-1:0]   out_value;
  cmd_t               cmd;
  sts_t               sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_count <= COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_count <= cfg_data;
    end
  end

  mtbol_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_mode  (s_axis_tuser),
    .sts      (sts),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  mtbol_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .entry_in     (s_axis_tdata[ENTRY_W-1:0]),
    .active_count (active_count),
    .out_ready    (m_axis_tready),
    .sts          (sts),
    .out_valid    (m_axis_tvalid),
    .out_value    (out_value),
    .out_last     (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, out_value};

`include "move_to_back_order_list_assert.svh"

  `MTBOL_ASSERT_NXT(a_move_seq, clk, rst, cmd.move_rank, cmd.move_update, "move skipped update")
  `MTBOL_ASSERT_IMP(a_one_cmd, clk, rst, 1'b1,
    $onehot0({cmd.load, cmd.move_rank, cmd.move_update, cmd.dump_step}), "command overlap")
  `MTBOL_ASSERT_NXT(a_dump_end, clk, rst, cmd.dump_step && sts.dump_final,
    s_axis_tready && m_axis_tvalid && m_axis_tlast, "dump end not marked")

endmodule
`default_nettype wire

>>> bench/tb_move_to_back_order_list.sv
`timescale 1ns / 1ps
module tb_move_to_back_order_list;
  import mtbol_pkg::*;

  localparam int NUM_ENTRIES = 16;
  localparam int DRAIN_CYCLES = 64;
  localparam int NUM_PHASES = 8;
  localparam int RANDOM_PER_PHASE = 25;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [ENTRY_W-1:0] value;
  } order_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             last;
  } dump_entry_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;   // [3:0] entry_value
  logic [1:0]          s_axis_tuser = '0;   // [1:0] mode
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;        // [3:0] out_value
  logic                m_axis_tlast;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [COUNT_W-1:0]  cfg_data = COUNT_RESET;

  move_to_back_order_list #(
    .MAX_ENTRIES(NUM_ENTRIES)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  order_item_t        item_q[$];
  dump_entry_t        dump_q[$];
  logic [ENTRY_W-1:0] rank_of[NUM_ENTRIES];
  logic [COUNT_W-1:0] next_rank;
  logic [COUNT_W-1:0] list_size;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int err_count = 0;
  int items_sent = 0;
  int entries_seen = 0;
  int dumps_seen = 0;
  int phase_count[NUM_PHASES] = '{16, 4, 1, 9, 16, 2, 13, 16};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    err_count++;
  endtask

  function automatic int live_count();
    int n;
    n = list_size;
    if (n < 1) n = 1;
    if (n > NUM_ENTRIES) n = NUM_ENTRIES;
    return n;
  endfunction

  // update the rank table for one accepted item, queue any dump entries
  task automatic predict_item(input order_item_t it);
    int n;
    int pick;
    logic [ENTRY_W-1:0] r;
    logic [NUM_ENTRIES-1:0] taken;
    n = live_count();
    case (it.mode)
      MODE_LOAD: begin
        if (next_rank < n && it.value < n) begin
          rank_of[it.value] = next_rank[ENTRY_W-1:0];
          next_rank = next_rank + 1'b1;
        end
      end
      MODE_MOVE: begin
        if (it.value < n) begin
          r = rank_of[it.value];
          for (int e = 0; e < n; e++)
            if (rank_of[e] > r) rank_of[e] = rank_of[e] - 1'b1;
          rank_of[it.value] = ENTRY_W'(n - 1);
        end
      end
      MODE_DUMP: begin
        taken = '0;
        for (int k = 0; k < n; k++) begin
          pick = -1;
          for (int e = 0; e < n; e++)
            if (!taken[e] && (pick < 0 || rank_of[e] < rank_of[pick])) pick = e;
          taken[pick] = 1'b1;
          dump_q.push_back('{value: OUT_W'(pick), last: (k == n - 1)});
        end
        dumps_seen++;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : feed
    order_item_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (item_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = item_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, nxt.value};
        s_axis_tuser  <= nxt.mode;
        items_sent++;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch
    dump_entry_t exp_entry;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      if (s_axis_tvalid && s_axis_tready)
        predict_item('{mode: s_axis_tuser, value: s_axis_tdata[ENTRY_W-1:0]});
      if (m_axis_tvalid && m_axis_tready) begin
        entries_seen++;
        if (dump_q.size() == 0) begin
          report_mismatch($sformatf("unexpected entry %0d", m_axis_tdata[OUT_W-1:0]));
        end else begin
          exp_entry = dump_q.pop_front();
          if (m_axis_tdata[OUT_W-1:0] !== exp_entry.value)
            report_mismatch($sformatf("out_value %0d, expected %0d",
                                      m_axis_tdata[OUT_W-1:0], exp_entry.value));
          if (m_axis_tlast !== exp_entry.last)
            report_mismatch($sformatf("tlast %b, expected %b", m_axis_tlast, exp_entry.last));
        end
      end
    end
  end

  task automatic push_item(input logic [MODE_W-1:0] mode, input int value);
    item_q.push_back('{mode: mode, value: ENTRY_W'(value)});
  endtask

  function automatic order_item_t rand_item(input int n);
    int sel;
    order_item_t it;
    sel = $urandom_range(99);
    if (sel < 30) it.mode = MODE_LOAD;
    else if (sel < 65) it.mode = MODE_MOVE;
    else if (sel < 92) it.mode = MODE_DUMP;
    else it.mode = MODE_SPARE;
    if ($urandom_range(9) < 8) it.value = ENTRY_W'($urandom_range(n - 1));
    else it.value = ENTRY_W'($urandom_range(15));
    return it;
  endfunction

  task automatic wait_idle();
    do @(posedge clk); while (item_q.size() != 0 || s_axis_tvalid || dump_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= COUNT_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    list_size = COUNT_W'(value);
  endtask

  initial begin
    for (int e = 0; e < NUM_ENTRIES; e++) rank_of[e] = ENTRY_W'(e);
    next_rank = '0;
    list_size = COUNT_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) wait_idle();
      write_count(phase_count[p]);
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 48; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 48; end
        default: begin src_idle_pct = 17; sink_stall_pct = 17; end
      endcase
      if (p == 0) begin
        // reset order, partial loads with stale ranks, moves, unused mode
        push_item(MODE_DUMP, 0);
        push_item(MODE_LOAD, 15);
        push_item(MODE_LOAD, 0);
        push_item(MODE_LOAD, 7);
        push_item(MODE_DUMP, 0);
        push_item(MODE_MOVE, 15);
        push_item(MODE_MOVE, 0);
        push_item(MODE_MOVE, 8);
        push_item(MODE_DUMP, 15);
        push_item(MODE_SPARE, 15);
        push_item(MODE_SPARE, 0);
        push_item(MODE_DUMP, 0);
      end
      if (phase_count[p] == 1) begin
        // single entry: out-of-range loads and moves are dropped
        push_item(MODE_DUMP, 0);
        push_item(MODE_LOAD, 3);
        push_item(MODE_MOVE, 15);
        push_item(MODE_MOVE, 0);
        push_item(MODE_LOAD, 0);
        push_item(MODE_DUMP, 0);
      end
      for (int i = 0; i < RANDOM_PER_PHASE; i++)
        item_q.push_back(rand_item(phase_count[p]));
    end
    wait_idle();

    $display("run covered %0d items over %0d count settings", items_sent, NUM_PHASES);
    $display("%0d dumps, %0d dumped entries checked, %0d mismatches",
             dumps_seen, entries_seen, err_count);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
